### design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int BUFFER_DEPTH_DEF = 16;

    // Kind of an input transaction.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_LOAD = 2'd0;
    localparam kind_t KIND_POST = 2'd1;
    localparam kind_t KIND_IRQ  = 2'd2;

    // Configuration register indexes.
    typedef logic cfg_index_t;
    localparam cfg_index_t CFG_SLAVE_ADDRESS = 1'b0;
    localparam cfg_index_t CFG_READ_COMMAND  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STARTED,
        PH_SEND,
        PH_RESTART,
        PH_READDR,
        PH_RECEIVE,
        PH_COLLECT,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_WRITE   = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_RCEN    = 3'd4,
        ACT_ACK     = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    typedef struct packed {
        logic [6:0] slave_address;
        logic [7:0] read_command_id;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] load_byte;
        logic [3:0] load_index;
        logic [4:0] message_length;
        logic       start_seen;
        logic       buffer_full;
        logic       stop_seen;
        logic       ack_missing;
        logic [7:0] received_byte;
    } item_t;

    typedef struct packed {
        action_t    bus_action;
        logic [7:0] bus_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_done;
        logic [4:0] rx_count;
        logic       post_rejected;
        logic       aborted;
    } result_t;

endpackage

### design/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences an I2C master write with an optional read-back, one bus
// controller interrupt per step, from a buffered transmit message.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_tvalid / s_tready  one event: byte load, post, interrupt
//  m_       out        m_tvalid / m_tready  one bus action and receive status
//  cfg_     in         cfg_wr_en            slave address, read command byte
//
// Every input transaction yields exactly one result transaction. An event is
// registered on acceptance, together with a read of the transmit memory at
// the current send position; the state machine then forms the result into
// the output register once that register is free or drains. A new event is
// taken every cycle as long as the output register drains. The staged event
// uses the synchronous memory read, with forwarding from the committing event.
// Reset is synchronous and active low; the transmit memory is not cleared.
// A stalled output holds the staged event, and the input then stalls too.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] load_byte, [11:8] load_index, [16:12] message_length,
    // [17] start_seen, [18] buffer_full, [19] stop_seen, [20] ack_missing,
    // [28:21] received_byte, [31:29] zero
    input  logic [31:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] bus_byte, [8] rx_valid, [16:9] rx_data, [17] rx_done,
    // [22:18] rx_count, [23] post_rejected, [24] aborted, [31:25] zero
    output logic [31:0] m_tdata,
    // [2:0] bus_action
    output logic [2:0]  m_tuser,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    cfg_t        cfg_reg, cfg_next;
    logic        a_valid_reg, a_valid_next;
    item_t       a_item_reg;
    item_t       s_item;
    logic        m_tvalid_reg, m_tvalid_next;
    result_t     m_result_reg;
    result_t     result;

    logic        a_fire;
    logic        s_fire;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  store_data;

    // Unpack the incoming transaction.
    always_comb begin
        s_item.kind           = s_tuser;
        s_item.load_byte      = s_tdata[7:0];
        s_item.load_index     = s_tdata[11:8];
        s_item.message_length = s_tdata[16:12];
        s_item.start_seen     = s_tdata[17];
        s_item.buffer_full    = s_tdata[18];
        s_item.stop_seen      = s_tdata[19];
        s_item.ack_missing    = s_tdata[20];
        s_item.received_byte  = s_tdata[28:21];
    end

    // The staged event commits when the output register is free or drains
    // in the same cycle; the input side refills the stage at that edge.
    assign a_fire   = a_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (a_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Configuration decode; the user must write only while the block is idle (not enforced here).
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SLAVE_ADDRESS: cfg_next.slave_address   = cfg_wdata[6:0];
                CFG_READ_COMMAND:  cfg_next.read_command_id = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cfg_reg      <= '0;
        end else begin
            a_valid_reg  <= a_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_item_reg <= s_item;
        end
        if (a_fire) begin
            m_result_reg <= result;
        end
    end

    i2cms_tx_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_tx_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_data (store_data)
    );

    i2cms_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (a_fire),
        .item       (a_item_reg),
        .cfg        (cfg_reg),
        .store_data (store_data),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .result     (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_result_reg.bus_action;
    assign m_tdata  = {7'd0,
                       m_result_reg.aborted,
                       m_result_reg.post_rejected,
                       m_result_reg.rx_count,
                       m_result_reg.rx_done,
                       m_result_reg.rx_data,
                       m_result_reg.rx_valid,
                       m_result_reg.bus_byte};

endmodule

### design/i2cms_tx_store.sv
// ----------------------------------------------------------------------------
// i2cms_tx_store
// Transmit byte memory: one write port, one registered read port, with
// forwarding of a write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module i2cms_tx_store
    import i2cms_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The array reads the old contents on a collision, so the new byte is
    // kept aside and selected instead.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

### design/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state machine: decodes one transaction, forms its result and
// updates the phase, counters and store write when the transaction commits.
// ----------------------------------------------------------------------------
module i2cms_ctrl
    import i2cms_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          commit,
    input  item_t         item,
    input  cfg_t          cfg,
    input  logic [7:0]    store_data,
    output logic [AW-1:0] rd_addr,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output result_t       result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 5) ? CW : 5;
    localparam int IW = (AW > 4) ? AW : 4;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   tx_length_reg, tx_length_next;
    logic [CW-1:0]   tx_position_reg, tx_position_next;
    logic [CW-1:0]   rx_position_reg, rx_position_next;
    logic            pending_reg, pending_next;
    logic [7:0]      first_byte_reg;

    logic [CW-1:0]   tx_pos_inc;
    logic [CW-1:0]   rx_pos_inc;
    logic [MW-1:0]   rx_pos_ext;
    logic [MW-1:0]   mlen_ext;
    logic [CW-1:0]   mlen_sat;
    logic [IW-1:0]   lidx_ext;
    logic            load_ok;
    logic            start_bad;
    logic            send_last;
    logic            read_back;
    logic            rx_last;
    logic [7:0]      send_byte;

    assign tx_pos_inc = tx_position_reg + 1'b1;
    assign rx_pos_inc = rx_position_reg + 1'b1;
    assign rx_pos_ext = MW'(rx_pos_inc);
    assign mlen_ext   = MW'(item.message_length);
    assign lidx_ext   = IW'(item.load_index);
    assign load_ok    = 32'(item.load_index) < 32'(DEPTH);
    assign start_bad  = !item.start_seen || item.buffer_full;
    assign send_last  = tx_pos_inc >= tx_length_reg;
    assign read_back  = first_byte_reg == cfg.read_command_id;
    assign rx_last    = (rx_pos_inc >= DEPTH_C) || item.stop_seen;
    assign send_byte  = (tx_position_reg < DEPTH_C) ? store_data : 8'd0;

    always_comb begin
        if (mlen_ext == '0) begin
            mlen_sat = CW'(1);
        end else if (mlen_ext > MW'(DEPTH)) begin
            mlen_sat = DEPTH_C;
        end else begin
            mlen_sat = mlen_ext[CW-1:0];
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (item.kind == KIND_IRQ) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (pending_reg) begin
                        phase_next = PH_STARTED;
                    end
                end
                PH_STARTED: begin
                    phase_next = start_bad ? PH_IDLE : PH_SEND;
                end
                PH_SEND: begin
                    if (!item.buffer_full && send_last) begin
                        phase_next = read_back ? PH_RESTART : PH_STOP;
                    end
                end
                PH_RESTART: begin
                    phase_next = PH_READDR;
                end
                PH_READDR: begin
                    phase_next = start_bad ? PH_IDLE : PH_RECEIVE;
                end
                PH_RECEIVE: begin
                    phase_next = item.ack_missing ? PH_IDLE : PH_COLLECT;
                end
                PH_COLLECT: begin
                    if (item.buffer_full) begin
                        phase_next = rx_last ? PH_IDLE : PH_RECEIVE;
                    end
                end
                PH_STOP: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result and counter updates.
    always_comb begin
        result           = '0;
        result.bus_action = ACT_NONE;
        tx_length_next   = tx_length_reg;
        tx_position_next = tx_position_reg;
        rx_position_next = rx_position_reg;
        pending_next     = pending_reg;
        unique case (item.kind)
            KIND_LOAD: begin
            end
            KIND_POST: begin
                if (pending_reg) begin
                    result.post_rejected = 1'b1;
                end else begin
                    tx_length_next = mlen_sat;
                    pending_next   = 1'b1;
                end
            end
            KIND_IRQ: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (pending_reg) begin
                            pending_next      = 1'b0;
                            tx_position_next  = '0;
                            rx_position_next  = '0;
                            result.bus_action = ACT_START;
                        end
                    end
                    PH_STARTED: begin
                        if (start_bad) begin
                            result.aborted = 1'b1;
                        end else begin
                            result.bus_action = ACT_WRITE;
                            result.bus_byte   = {cfg.slave_address, 1'b0};
                            tx_position_next  = '0;
                        end
                    end
                    PH_SEND: begin
                        if (!item.buffer_full) begin
                            result.bus_action = ACT_WRITE;
                            result.bus_byte   = send_byte;
                            tx_position_next  = tx_pos_inc;
                            if (send_last && read_back) begin
                                rx_position_next = '0;
                            end
                        end
                    end
                    PH_RESTART: begin
                        result.bus_action = ACT_RESTART;
                    end
                    PH_READDR: begin
                        if (start_bad) begin
                            result.aborted = 1'b1;
                        end else begin
                            result.bus_action = ACT_WRITE;
                            result.bus_byte   = {cfg.slave_address, 1'b1};
                        end
                    end
                    PH_RECEIVE: begin
                        result.bus_action = item.ack_missing ? ACT_STOP : ACT_RCEN;
                    end
                    PH_COLLECT: begin
                        if (item.buffer_full) begin
                            result.rx_valid  = 1'b1;
                            result.rx_data   = item.received_byte;
                            rx_position_next = rx_pos_inc;
                            if (rx_last) begin
                                result.rx_done    = 1'b1;
                                result.rx_count   = rx_pos_ext[4:0];
                                result.bus_action = ACT_STOP;
                            end else begin
                                result.bus_action = ACT_ACK;
                            end
                        end
                    end
                    PH_STOP: begin
                        result.bus_action = ACT_STOP;
                    end
                    default: begin
                        result.bus_action = ACT_STOP;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // A byte load goes to the memory when it commits; entry zero is also
    // mirrored here for the read-back decision.
    assign wr_en   = commit && (item.kind == KIND_LOAD) && load_ok;
    assign wr_addr = lidx_ext[AW-1:0];
    assign wr_data = item.load_byte;

    // The next transaction reads the position that this one leaves behind.
    assign rd_addr = commit ? tx_position_next[AW-1:0] : tx_position_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tx_length_reg   <= '0;
            tx_position_reg <= '0;
            rx_position_reg <= '0;
            pending_reg     <= 1'b0;
        end else if (commit) begin
            phase_reg       <= phase_next;
            tx_length_reg   <= tx_length_next;
            tx_position_reg <= tx_position_next;
            rx_position_reg <= rx_position_next;
            pending_reg     <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (lidx_ext == '0)) begin
            first_byte_reg <= item.load_byte;
        end
    end

endmodule

### sim/i2c_transfer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_transfer_checker
// Watches the event, result and register channels of the transfer sequencer,
// predicts each bus step and compares it with what the block returns.
// ----------------------------------------------------------------------------
module i2c_transfer_checker
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [2:0]  m_tuser,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,

    output int          fail_count
);

    localparam int DEPTH        = BUFFER_DEPTH_DEF;
    localparam int REPORT_LIMIT = 10;

    // Shadow of the sequencer state and its registers.
    phase_t     seq_phase;
    logic [7:0] tx_bytes [DEPTH];
    logic [4:0] tx_length;
    logic [4:0] tx_pos;
    logic [4:0] rx_pos;
    logic       msg_pending;
    logic [6:0] target_address;
    logic [7:0] read_command;

    result_t    expected_steps [$];
    int         mismatches = 0;
    int         backlog    = 0;

    assign fail_count = mismatches + backlog;

    function automatic logic [7:0] tx_byte_at(input logic [4:0] pos);
        return (pos < DEPTH) ? tx_bytes[pos] : 8'h00;
    endfunction

    // Applies one event to the shadow state and returns the bus step it causes.
    function automatic result_t advance_sequencer(input item_t ev);
        result_t    r;
        logic [4:0] len;
        r = '0;
        case (ev.kind)
            KIND_LOAD: begin
                if (ev.load_index < DEPTH)
                    tx_bytes[ev.load_index] = ev.load_byte;
            end
            KIND_POST: begin
                if (msg_pending) begin
                    r.post_rejected = 1'b1;
                end else begin
                    len = ev.message_length;
                    if (len == 5'd0)
                        len = 5'd1;
                    if (len > DEPTH)
                        len = 5'(DEPTH);
                    tx_length   = len;
                    msg_pending = 1'b1;
                end
            end
            KIND_IRQ: begin
                case (seq_phase)
                    PH_IDLE: begin
                        if (msg_pending) begin
                            msg_pending  = 1'b0;
                            tx_pos       = 5'd0;
                            rx_pos       = 5'd0;
                            r.bus_action = ACT_START;
                            seq_phase    = PH_STARTED;
                        end
                    end
                    PH_STARTED: begin
                        if (!ev.start_seen || ev.buffer_full) begin
                            r.aborted = 1'b1;
                            seq_phase = PH_IDLE;
                        end else begin
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = {target_address, 1'b0};
                            tx_pos       = 5'd0;
                            seq_phase    = PH_SEND;
                        end
                    end
                    PH_SEND: begin
                        if (!ev.buffer_full) begin
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = tx_byte_at(tx_pos);
                            tx_pos       = tx_pos + 5'd1;
                            if (tx_pos >= tx_length) begin
                                if (tx_byte_at(5'd0) == read_command) begin
                                    rx_pos    = 5'd0;
                                    seq_phase = PH_RESTART;
                                end else begin
                                    seq_phase = PH_STOP;
                                end
                            end
                        end
                    end
                    PH_RESTART: begin
                        r.bus_action = ACT_RESTART;
                        seq_phase    = PH_READDR;
                    end
                    PH_READDR: begin
                        if (!ev.start_seen || ev.buffer_full) begin
                            r.aborted = 1'b1;
                            seq_phase = PH_IDLE;
                        end else begin
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = {target_address, 1'b1};
                            seq_phase    = PH_RECEIVE;
                        end
                    end
                    PH_RECEIVE: begin
                        if (ev.ack_missing) begin
                            r.bus_action = ACT_STOP;
                            seq_phase    = PH_IDLE;
                        end else begin
                            r.bus_action = ACT_RCEN;
                            seq_phase    = PH_COLLECT;
                        end
                    end
                    PH_COLLECT: begin
                        if (ev.buffer_full) begin
                            r.rx_valid = 1'b1;
                            r.rx_data  = ev.received_byte;
                            rx_pos     = rx_pos + 5'd1;
                            if (rx_pos >= DEPTH || ev.stop_seen) begin
                                r.rx_done    = 1'b1;
                                r.rx_count   = rx_pos;
                                r.bus_action = ACT_STOP;
                                seq_phase    = PH_IDLE;
                            end else begin
                                r.bus_action = ACT_ACK;
                                seq_phase    = PH_RECEIVE;
                            end
                        end
                    end
                    default: begin
                        r.bus_action = ACT_STOP;
                        seq_phase    = PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%0t %s: expected act %0d byte %02h rx %0b/%02h done %0b/%0d",
                      " rej %0b abt %0b; got act %0d byte %02h rx %0b/%02h",
                      " done %0b/%0d rej %0b abt %0b"},
                     $time, what, want.bus_action, want.bus_byte, want.rx_valid, want.rx_data,
                     want.rx_done, want.rx_count, want.post_rejected, want.aborted,
                     got.bus_action, got.bus_byte, got.rx_valid, got.rx_data,
                     got.rx_done, got.rx_count, got.post_rejected, got.aborted);
    endtask

    always @(posedge aclk) begin : monitor
        item_t   ev;
        result_t got;
        result_t want;
        if (!aresetn) begin
            seq_phase      = PH_IDLE;
            tx_length      = 5'd0;
            tx_pos         = 5'd0;
            rx_pos         = 5'd0;
            msg_pending    = 1'b0;
            target_address = 7'd0;
            read_command   = 8'd0;
            for (int i = 0; i < DEPTH; i++)
                tx_bytes[i] = 8'h00;
            expected_steps.delete();
            backlog = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SLAVE_ADDRESS)
                    target_address = cfg_wdata[6:0];
                else
                    read_command = cfg_wdata;
            end
            // Results are matched before this edge's event is predicted, since
            // the block registers each event before it answers.
            if (m_tvalid && m_tready) begin
                got.bus_action    = action_t'(m_tuser);
                got.bus_byte      = m_tdata[7:0];
                got.rx_valid      = m_tdata[8];
                got.rx_data       = m_tdata[16:9];
                got.rx_done       = m_tdata[17];
                got.rx_count      = m_tdata[22:18];
                got.post_rejected = m_tdata[23];
                got.aborted       = m_tdata[24];
                if (expected_steps.size() == 0) begin
                    log_mismatch("result with nothing outstanding", '0, got);
                end else begin
                    want = expected_steps.pop_front();
                    if (got !== want)
                        log_mismatch("bus step mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                ev.kind           = s_tuser;
                ev.load_byte      = s_tdata[7:0];
                ev.load_index     = s_tdata[11:8];
                ev.message_length = s_tdata[16:12];
                ev.start_seen     = s_tdata[17];
                ev.buffer_full    = s_tdata[18];
                ev.stop_seen      = s_tdata[19];
                ev.ack_missing    = s_tdata[20];
                ev.received_byte  = s_tdata[28:21];
                expected_steps.push_back(advance_sequencer(ev));
            end
            backlog = expected_steps.size();
        end
    end

endmodule

### sim/tb_i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer
// Stimulus and verdict for the I2C master transfer sequencer. A short directed
// walk through one write-then-read transfer and its corner cases is followed
// by randomized transfers under several register settings, with random
// stalls on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
    import i2cms_pkg::*;

    localparam int    DEPTH           = BUFFER_DEPTH_DEF;
    localparam int    RESET_CYCLES    = 12;
    localparam int    RANDOM_PHASES   = 5;
    localparam int    ITEMS_PER_PHASE = 230;
    localparam int    LONG_HOLD       = 300;
    localparam int    DRAIN_LIMIT     = 5000;
    localparam int    TAIL_CYCLES     = 8;
    // The kind code the block has no meaning for; it must be ignored.
    localparam kind_t KIND_UNUSED     = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [7:0]  cfg_wdata;

    int          fail_count;
    int unsigned items_sent;
    int unsigned results_seen;

    // Controls for the sender and the result sink.
    bit          quiet;          // no idling on either side
    bit          hold_off;       // asks the sink for one long stall
    bit          status_noise;   // lets interrupts carry an occasional wrong status bit
    int unsigned tx_calm;        // transactions left in a stretch without sender gaps

    // What the stimulus believes about the block, used only to shape transfers.
    logic [7:0]  entry0_shadow;
    logic [7:0]  cur_command;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    i2c_master_transfer_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    i2c_transfer_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count)
    );

    // Counts result transactions with a nonblocking update, so a read that races the
    // update sees the older, smaller total and any wait on it errs on the safe side.
    always @(posedge aclk) begin
        if (!aresetn)
            results_seen <= 0;
        else if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
    end

    // One random status bit.
    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Every field random, kind included; the unused fields of each kind are
    // kept random on purpose so the block is seen to ignore them.
    function automatic item_t any_item();
        item_t it;
        it.kind           = kind_t'($urandom_range(0, 3));
        it.load_byte      = 8'($urandom_range(0, 255));
        it.load_index     = 4'($urandom_range(0, 15));
        it.message_length = 5'($urandom_range(0, 31));
        it.start_seen     = coin();
        it.buffer_full    = coin();
        it.stop_seen      = coin();
        it.ack_missing    = coin();
        it.received_byte  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic item_t load_item(input logic [3:0] idx, input logic [7:0] val);
        item_t it;
        it            = any_item();
        it.kind       = KIND_LOAD;
        it.load_index = idx;
        it.load_byte  = val;
        return it;
    endfunction

    function automatic item_t post_item(input logic [4:0] len);
        item_t it;
        it                = any_item();
        it.kind           = KIND_POST;
        it.message_length = len;
        return it;
    endfunction

    // An interrupt with the given bus status. With noise enabled, one status
    // bit is now and then flipped so that transfers also break off midway.
    function automatic item_t irq_item(input bit st, input bit bf, input bit sp, input bit nack);
        item_t      it;
        logic [3:0] status;
        status = {nack, sp, bf, st};
        if (status_noise && $urandom_range(0, 29) == 0)
            status = status ^ (4'b0001 << $urandom_range(0, 3));
        it      = any_item();
        it.kind = KIND_IRQ;
        {it.ack_missing, it.stop_seen, it.buffer_full, it.start_seen} = status;
        return it;
    endfunction

    // Offers one transaction and holds it until the block takes it. A random
    // gap may come first; valid changes at most once per clock edge.
    task automatic offer(input item_t it);
        if (!quiet && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        if (tx_calm != 0)
            tx_calm--;
        else if ($urandom_range(0, 40) == 0)
            tx_calm = $urandom_range(15, 50);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.received_byte, it.ack_missing, it.stop_seen, it.buffer_full,
                     it.start_seen, it.message_length, it.load_index, it.load_byte};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (it.kind == KIND_LOAD && it.load_index == 4'd0)
            entry0_shadow = it.load_byte;
    endtask

    // Stops offering and waits until every transaction has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (items_sent != results_seen);
    endtask

    // Writes both registers back to back; only called with the block drained.
    task automatic set_registers(input logic [6:0] addr, input logic [7:0] cmd);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SLAVE_ADDRESS;
        cfg_wdata <= {1'b0, addr};
        @(posedge aclk);
        cfg_addr  <= CFG_READ_COMMAND;
        cfg_wdata <= cmd;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_command = cmd;
    endtask

    // One well-formed transfer with random content: loads, a post, the start
    // and address steps, every message byte, and then either the stop or the
    // whole read-back. Stray loads, posts and buffer-busy interrupts are mixed
    // in so that waits and changes during a running transfer are exercised.
    task automatic run_transfer();
        logic [4:0]  mlen;
        int unsigned nbytes;
        int unsigned stop_odds;
        bit          sp;
        bit          nack;
        repeat ($urandom_range(0, 3))
            offer(load_item(4'($urandom_range(0, DEPTH - 1)), 8'($urandom_range(0, 255))));
        // Most transfers ask for a read-back by leading with the command byte.
        if ($urandom_range(0, 4) < 3)
            offer(load_item(4'd0, cur_command));
        // Mostly short messages; now and then the full store, zero or oversize.
        case ($urandom_range(0, 9))
            0:       mlen = 5'd0;
            1:       mlen = 5'($urandom_range(17, 31));
            2:       mlen = 5'(DEPTH);
            3:       mlen = 5'($urandom_range(5, 15));
            default: mlen = 5'($urandom_range(1, 4));
        endcase
        offer(post_item(mlen));
        nbytes = (mlen == 5'd0) ? 1 : (mlen > DEPTH) ? DEPTH : mlen;

        offer(irq_item(coin(), coin(), coin(), coin()));
        offer(irq_item(1'b1, 1'b0, coin(), coin()));
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0)
                offer(irq_item(1'b1, 1'b1, coin(), coin()));
            if ($urandom_range(0, 11) == 0)
                offer(load_item(4'($urandom_range(0, DEPTH - 1)),
                                8'($urandom_range(0, 255))));
            if ($urandom_range(0, 19) == 0)
                offer(post_item(5'($urandom_range(0, 31))));
            offer(irq_item(coin(), 1'b0, coin(), coin()));
        end

        if (entry0_shadow == cur_command) begin
            // Repeated start, then the address with the read bit.
            offer(irq_item(coin(), coin(), coin(), coin()));
            offer(irq_item(1'b1, 1'b0, coin(), coin()));
            // A stop chance of zero lets the reception run until the buffer is full.
            stop_odds = $urandom_range(0, 8);
            for (int n = 0; n < DEPTH; n++) begin
                nack = ($urandom_range(0, 11) == 0);
                offer(irq_item(coin(), coin(), coin(), nack));
                if (nack)
                    break;
                if ($urandom_range(0, 5) == 0)
                    offer(irq_item(coin(), 1'b0, coin(), coin()));
                sp = (stop_odds != 0 && $urandom_range(1, stop_odds) == 1);
                offer(irq_item(coin(), 1'b1, sp, coin()));
                if (sp)
                    break;
            end
        end else begin
            // Write-only transfer: the next interrupt closes it with a stop.
            offer(irq_item(coin(), coin(), coin(), coin()));
        end
    endtask

    // Result sink. It stalls in short random bursts, takes calm stretches with
    // no stalls at all, and on request holds off for a long count of cycles so
    // that the block backs up and stalls its input.
    initial begin : result_sink
        int unsigned calm_left;
        calm_left = 0;
        m_tready <= 1'b0;
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                if (calm_left != 0)
                    calm_left--;
                else if ($urandom_range(0, 15) == 0)
                    calm_left = $urandom_range(20, 60);
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        item_t       odd;
        int unsigned phase_end;
        int unsigned guard;
        bit          paused;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_LOAD;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_SLAVE_ADDRESS;
        cfg_wdata <= '0;
        quiet         = 1'b0;
        hold_off      = 1'b0;
        status_noise  = 1'b0;
        tx_calm       = 0;
        items_sent    = 0;
        entry0_shadow = 8'h00;
        cur_command   = 8'h00;
        paused        = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk: highest address, a command byte with mixed bits.
        set_registers(7'd127, 8'hA5);
        offer(load_item(4'd0, 8'hA5));          // first byte calls for a read-back
        offer(load_item(4'd15, 8'hFF));
        offer(load_item(4'd1, 8'h00));
        offer(irq_item(1'b0, 1'b0, 1'b0, 1'b0)); // idle with nothing posted: no step
        odd      = any_item();
        odd.kind = KIND_UNUSED;
        offer(odd);                               // unknown kind is ignored
        offer(post_item(5'd0));                   // zero length counts as one byte
        offer(post_item(5'd31));                  // refused, a message is pending
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // start
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // address with write bit
        offer(irq_item(1'b1, 1'b1, 1'b0, 1'b0)); // buffer still full: wait
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // the only byte, read-back follows
        offer(post_item(5'd31));                  // taken while running, cut to the store size
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // repeated start
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // address with read bit
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // receive enable
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // nothing received yet: wait
        offer(irq_item(1'b1, 1'b1, 1'b0, 1'b0)); // byte in, acknowledge
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b1)); // missing acknowledge: stop
        offer(irq_item(1'b1, 1'b0, 1'b0, 1'b0)); // start of the pending message
        offer(irq_item(1'b0, 1'b0, 1'b0, 1'b0)); // no start seen: abort
        drain();

        // Random phases, each under its own register setting. The first one
        // fills the whole store so no transfer ever sends an unwritten entry.
        status_noise = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       set_registers(7'd0, 8'h00);
                1:       set_registers(7'd127, 8'hFF);
                default: set_registers(7'($urandom_range(1, 126)), 8'($urandom_range(1, 254)));
            endcase
            quiet = (p == RANDOM_PHASES - 1);
            if (p == 0) begin
                for (int i = 0; i < DEPTH; i++)
                    offer(load_item(4'(i), 8'($urandom_range(0, 255))));
            end
            // The sink stalls for a long stretch while the sender keeps going.
            if (p == 1)
                hold_off = 1'b1;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4))
                        offer(any_item());
                end
                run_transfer();
                // Midway through one phase the sender waits for every result.
                if (p == 2 && !paused && items_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            if (p != RANDOM_PHASES - 1)
                drain();
        end

        // Let the last results come out, with a bound in case the block hangs.
        s_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (items_sent != results_seen && guard < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (items_sent == results_seen && fail_count == 0)
            $display("tb_i2c_master_transfer_sequencer: done, clean");
        else
            $display("tb_i2c_master_transfer_sequencer: done, errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin : watchdog
        #4_000_000;
        $display("tb_i2c_master_transfer_sequencer: done, errors");
        $finish;
    end

endmodule
